// ===== rtl/core/bv6_pkg.sv =====
package bv6_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       frame_start;
	} in_item_t;

	typedef struct packed {
		logic [4:0]  field_id;
		logic [63:0] field_value;
		logic        field_done;
		logic [7:0]  block_kind;
		logic [1:0]  parse_status;
		logic [2:0]  error_code;
		logic        bundle_accepted;
		logic        last;
	} out_item_t;

	localparam logic [4:0] ST_NONE      = 5'd0;
	localparam logic [4:0] ST_VERSION   = 5'd1;
	localparam logic [4:0] ST_PROC      = 5'd2;
	localparam logic [4:0] ST_PLEN      = 5'd3;
	localparam logic [4:0] ST_DEST_SCH  = 5'd4;
	localparam logic [4:0] ST_TIMESTAMP = 5'd12;
	localparam logic [4:0] ST_SEQ       = 5'd13;
	localparam logic [4:0] ST_LIFETIME  = 5'd14;
	localparam logic [4:0] ST_DLEN      = 5'd15;
	localparam logic [4:0] ST_DICT      = 5'd16;
	localparam logic [4:0] ST_FRAG      = 5'd17;
	localparam logic [4:0] ST_ADU       = 5'd18;
	localparam logic [4:0] ST_TYPE      = 5'd19;
	localparam logic [4:0] ST_BFLAGS    = 5'd20;
	localparam logic [4:0] ST_RCNT      = 5'd21;
	localparam logic [4:0] ST_RSCH      = 5'd22;
	localparam logic [4:0] ST_RSSP      = 5'd23;
	localparam logic [4:0] ST_DATALEN   = 5'd24;
	localparam logic [4:0] ST_DATA      = 5'd25;
	localparam logic [4:0] ST_DONE      = 5'd26;

	localparam logic [1:0] STAT_PARSING = 2'd0;
	localparam logic [1:0] STAT_DONE    = 2'd1;
	localparam logic [1:0] STAT_ERROR   = 2'd2;

	localparam logic [2:0] ERR_NONE     = 3'd0;
	localparam logic [2:0] ERR_SDNV     = 3'd1;
	localparam logic [2:0] ERR_PRIMARY  = 3'd2;
	localparam logic [2:0] ERR_DICT     = 3'd3;
	localparam logic [2:0] ERR_QUOTA    = 3'd4;

	localparam logic [0:0] CFG_QUOTA = 1'b0;
	localparam logic [0:0] CFG_BASE  = 1'b1;

	localparam logic [31:0] QUOTA_RESET      = 32'd65536;
	localparam logic [63:0] PROC_IS_FRAGMENT = 64'h1;
	localparam logic [63:0] BLK_FLAG_LAST    = 64'h8;
	localparam logic [63:0] BLK_FLAG_HAS_EID = 64'h40;
	localparam logic [7:0]  BLK_TYPE_PAYLOAD = 8'd1;

	// SDNV field width in bits per stage; 0 for raw-byte stages.
	function automatic logic [6:0] field_width(input logic [4:0] s);
		logic [6:0] w;
		case (s)
			ST_PROC, ST_FRAG, ST_ADU, ST_BFLAGS, ST_DATALEN: w = 7'd32;
			ST_TIMESTAMP, ST_LIFETIME: w = 7'd64;
			ST_PLEN, ST_SEQ, ST_DLEN, ST_RCNT, ST_RSCH, ST_RSSP: w = 7'd16;
			default: w = (s >= ST_DEST_SCH && s < ST_TIMESTAMP) ? 7'd16 : 7'd0;
		endcase
		return w;
	endfunction

	function automatic logic pair_ok(input logic [15:0] sch, input logic [15:0] ssp,
		input logic [15:0] dl);
		return (sch != ssp) && (sch < dl) && (ssp < dl);
	endfunction

endpackage

// ===== rtl/core/bv6_front.sv =====
module bv6_front
	import bv6_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_item_t in_data,
	output logic     q_valid,
	input  logic     q_ready,
	output in_item_t q_data
);

	// Two-entry queue decoupling input acceptance from the parser core.
	logic [1:0] cnt_q;
	logic       rd_q, wr_q;
	in_item_t   mem_q [2];

	logic push, pop;

	assign in_ready = (cnt_q != 2'd2);
	assign q_valid  = (cnt_q != 2'd0);
	assign q_data   = mem_q[rd_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'd2)
		else $error("queue count out of range");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0) |-> !q_valid)
		else $error("empty queue shows valid");
	assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (cnt_q == $past(cnt_q) + 2'd1))
		else $error("push lost");

endmodule

// ===== rtl/core/bv6_back.sv =====
module bv6_back
	import bv6_pkg::*;
#(
	parameter int EID_REF_BYTES = 4
)
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_valid,
	output logic      q_ready,
	input  in_item_t  q_data,
	input  logic      cfg_we,
	input  logic      cfg_sel,
	input  logic [31:0] cfg_wdata,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	localparam logic [32:0] REF_BYTES = 33'(EID_REF_BYTES);

	logic [31:0] quota_q, base_q;
	logic [4:0]  stage_q;
	logic [63:0] acc_q;
	logic [15:0] prim_left_q, ref_idx_q, ref_tot_q, dict_len_q, pend_q;
	logic [31:0] bytes_left_q;
	logic [15:0] offs_q [8];
	logic [32:0] usage_q;
	logic        fl_frag_q, fl_last_q, fl_pay_q, fl_bad_q;
	logic [1:0]  status_q;
	logic [2:0]  err_q;
	logic [7:0]  kind_q;

	out_item_t out_q;
	logic      out_v_q;

	assign q_ready   = !out_v_q || out_ready;
	assign out_valid = out_v_q;
	assign out_data  = out_q;

	// Effective state after an optional frame restart.
	logic        fs;
	logic [4:0]  st;
	logic [63:0] acc;
	logic [15:0] pl, rtot, rid, dl, pend;
	logic [31:0] bl;
	logic [32:0] use0;
	logic        ffrag, flast, fpay, fbad;
	logic [1:0]  stat;
	logic [2:0]  erc;
	logic [7:0]  kind;
	logic [15:0] offs [8];
	logic [7:0]  b;

	// Next values.
	logic [4:0]  nxt;
	logic [2:0]  err;
	logic [4:0]  fid;
	logic [63:0] val;
	logic        done, fin, accd;
	logic [63:0] acc_n;
	logic        sd_ovf;
	logic [6:0]  w;
	logic [32:0] add_amt, use_n;
	logic        use_upd;
	logic        over;
	logic [15:0] pl_n, rid_n, rtot_n, dl_n, pend_n;
	logic [31:0] bl_n;
	logic        ffrag_n, flast_n, fpay_n, fbad_n;
	logic [7:0]  kind_n;
	logic        off_we;
	logic [2:0]  off_idx;
	logic        prim_chk;

	always_comb begin
		b  = q_data.data_byte;
		fs = q_data.frame_start;
		st    = fs ? ST_VERSION : stage_q;
		acc   = fs ? 64'd0 : acc_q;
		pl    = fs ? 16'd0 : prim_left_q;
		rtot  = fs ? 16'd0 : ref_tot_q;
		rid   = fs ? 16'd0 : ref_idx_q;
		dl    = fs ? 16'd0 : dict_len_q;
		pend  = fs ? 16'd0 : pend_q;
		bl    = fs ? 32'd0 : bytes_left_q;
		use0  = fs ? {1'b0, base_q} : usage_q;
		ffrag = fs ? 1'b0 : fl_frag_q;
		flast = fs ? 1'b0 : fl_last_q;
		fpay  = fs ? 1'b0 : fl_pay_q;
		fbad  = fs ? 1'b0 : fl_bad_q;
		stat  = fs ? STAT_PARSING : status_q;
		erc   = fs ? ERR_NONE : err_q;
		kind  = fs ? 8'd0 : kind_q;
		for (int i = 0; i < 8; i++) begin
			offs[i] = fs ? 16'd0 : offs_q[i];
		end
	end

	always_comb begin
		nxt = st; err = ERR_NONE; fid = ST_NONE; val = 64'd0; done = 1'b0;
		fin = 1'b0; accd = 1'b0; acc_n = acc; sd_ovf = 1'b0;
		w = field_width(st); add_amt = 33'd0; use_upd = 1'b0;
		pl_n = pl; rid_n = rid; rtot_n = rtot; dl_n = dl; pend_n = pend; bl_n = bl;
		ffrag_n = ffrag; flast_n = flast; fpay_n = fpay; fbad_n = fbad; kind_n = kind;
		off_we = 1'b0; off_idx = 3'(st - ST_DEST_SCH);
		prim_chk = (st >= ST_DEST_SCH) && (st < ST_TYPE);
		use_n = use0;
		over = 1'b0;
		if (stat == STAT_PARSING) begin
			if (prim_chk) begin
				if (pl == 16'd0) begin
					err = ERR_PRIMARY;
				end else begin
					pl_n = pl - 16'd1;
				end
			end
			if (err == ERR_NONE) begin
				fid = st;
				case (st)
					ST_VERSION: begin
						val = {56'd0, b}; done = 1'b1; nxt = ST_PROC;
					end
					ST_DICT, ST_DATA: begin
						val = {56'd0, b};
						bl_n = bl - 32'd1;
						if (bl_n == 32'd0) begin
							done = 1'b1;
							if (st == ST_DICT) begin
								nxt = ffrag ? ST_FRAG : ST_TYPE;
							end else begin
								nxt = flast ? ST_DONE : ST_TYPE;
							end
						end
					end
					ST_TYPE: begin
						val = {56'd0, b}; done = 1'b1; kind_n = b;
						if (b == BLK_TYPE_PAYLOAD) begin
							fpay_n = 1'b1;
						end
						nxt = ST_BFLAGS;
					end
					default: begin
						sd_ovf = (acc >> (w - 7'd7)) != 64'd0;
						if (sd_ovf) begin
							err = ERR_SDNV;
						end else begin
							acc_n = {acc[56:0], b[6:0]};
							val = acc_n;
							if (!b[7]) begin
								done = 1'b1;
								case (st)
									ST_PROC: begin
										if ((acc_n & PROC_IS_FRAGMENT) != 64'd0) begin
											ffrag_n = 1'b1;
										end
										nxt = ST_PLEN;
									end
									ST_PLEN: begin
										pl_n = acc_n[15:0]; nxt = ST_DEST_SCH;
									end
									ST_DLEN: begin
										dl_n = acc_n[15:0];
										if (dl_n == 16'd0) begin
											err = ERR_DICT;
										end else begin
											bl_n = {16'd0, dl_n};
											add_amt = {17'd0, dl_n} + 33'd1;
											use_upd = 1'b1;
											nxt = ST_DICT;
										end
									end
									ST_ADU: nxt = ST_TYPE;
									ST_BFLAGS: begin
										flast_n = (acc_n & BLK_FLAG_LAST) != 64'd0;
										nxt = ((acc_n & BLK_FLAG_HAS_EID)
											!= 64'd0) ? ST_RCNT : ST_DATALEN;
									end
									ST_RCNT: begin
										rtot_n = acc_n[15:0]; rid_n = 16'd0;
										add_amt = 33'(REF_BYTES * {17'd0, rtot_n});
										use_upd = 1'b1;
										nxt = (rtot_n == 16'd0) ? ST_DATALEN : ST_RSCH;
									end
									ST_RSCH: begin
										pend_n = acc_n[15:0]; nxt = ST_RSSP;
									end
									ST_RSSP: begin
										if (!pair_ok(pend, acc_n[15:0], dl)) begin
											fbad_n = 1'b1;
										end
										rid_n = rid + 16'd1;
										nxt = (rid_n == rtot) ? ST_DATALEN : ST_RSCH;
									end
									ST_DATALEN: begin
										bl_n = acc_n[31:0];
										add_amt = {1'b0, acc_n[31:0]};
										use_upd = 1'b1;
										nxt = (bl_n == 32'd0) ? (flast ? ST_DONE : ST_TYPE)
											: ST_DATA;
									end
									default: begin
										// Only the eight EID offset fields are kept.
										if (st >= ST_DEST_SCH && st < ST_TIMESTAMP) begin
											off_we = 1'b1;
										end
										nxt = st + 5'd1;
									end
								endcase
								if (use_upd) begin
									use_n = use0 + add_amt;
									over = use_n > {1'b0, quota_q};
									if (over) begin
										err = ERR_QUOTA;
										nxt = st;
									end
								end
							end
						end
					end
				endcase
			end
			if (err == ERR_SDNV || err == ERR_PRIMARY) begin
				val = 64'd0; done = 1'b0;
			end
			if (err == ERR_PRIMARY) begin
				fid = ST_NONE;
			end
			if (err == ERR_NONE && nxt == ST_DONE) begin
				fin = 1'b1;
				accd = fpay && !fbad_n;
				for (int k = 0; k < 8; k += 2) begin
					if (!pair_ok(offs[k], offs[k+1], dl)) begin
						accd = 1'b0;
					end
				end
			end
		end
	end

	logic take;
	assign take = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (take) begin
			out_q.field_id        <= fid;
			out_q.field_value     <= val;
			out_q.field_done      <= done;
			out_q.block_kind      <= kind_n;
			out_q.parse_status    <= (err != ERR_NONE) ? STAT_ERROR
				: (fin ? STAT_DONE : stat);
			out_q.error_code      <= (err != ERR_NONE) ? err : erc;
			out_q.bundle_accepted <= accd;
			out_q.last            <= fin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quota_q <= QUOTA_RESET; base_q <= 32'd0;
			stage_q <= ST_VERSION; acc_q <= 64'd0; prim_left_q <= 16'd0;
			bytes_left_q <= 32'd0; ref_idx_q <= 16'd0; ref_tot_q <= 16'd0;
			dict_len_q <= 16'd0; pend_q <= 16'd0; usage_q <= 33'd0;
			fl_frag_q <= 1'b0; fl_last_q <= 1'b0; fl_pay_q <= 1'b0; fl_bad_q <= 1'b0;
			status_q <= STAT_PARSING; err_q <= ERR_NONE; kind_q <= 8'd0;
			for (int i = 0; i < 8; i++) begin
				offs_q[i] <= 16'd0;
			end
			out_v_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_sel == CFG_QUOTA) begin
					quota_q <= cfg_wdata;
				end else begin
					base_q <= cfg_wdata;
				end
			end
			if (take) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
			if (take) begin
				prim_left_q <= pl_n; bytes_left_q <= bl_n; ref_idx_q <= rid_n;
				ref_tot_q <= rtot_n; dict_len_q <= dl_n; pend_q <= pend_n;
				usage_q <= use_n; fl_frag_q <= ffrag_n; fl_last_q <= flast_n;
				fl_pay_q <= fpay_n; fl_bad_q <= fbad_n; kind_q <= kind_n;
				for (int i = 0; i < 8; i++) begin
					offs_q[i] <= (off_we && err == ERR_NONE && off_idx == 3'(i))
						? acc_n[15:0] : offs[i];
				end
				if (err != ERR_NONE) begin
					status_q <= STAT_ERROR; err_q <= err;
					stage_q <= st; acc_q <= acc_n;
				end else begin
					err_q <= erc;
					status_q <= fin ? STAT_DONE : stat;
					stage_q <= nxt;
					acc_q <= (nxt != st) ? 64'd0 : acc_n;
				end
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("result dropped while stalled");
	assert property (@(posedge clk) disable iff (!arst_n)
		(status_q == STAT_ERROR) |-> (err_q != ERR_NONE))
		else $error("error status without code");
	assert property (@(posedge clk) disable iff (!arst_n)
		(status_q == STAT_DONE) |-> (stage_q == ST_DONE))
		else $error("done status off the done stage");

endmodule

// ===== rtl/core/bundle_v6_header_parser.sv =====
// Channel   Signals                              Direction
// in        in_valid/in_ready, in_data          into block
// out       out_valid/out_ready, out_data       out of block
// cfg       cfg_valid/cfg_ready, cfg_index/data into block
//
// One byte is taken per cycle while the output is not stalled; each result is
// registered and appears in the cycle after its byte leaves the two-entry input queue.
// Reset restores quota 65536, base usage 0 and the version stage.
// Either side may stall; the queue and the output register absorb it.
module bundle_v6_header_parser
	import bv6_pkg::*;
#(
	parameter int EID_REF_BYTES = 4
)
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_item_t   out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	logic     q_valid, q_ready;
	in_item_t q_data;

	assign cfg_ready = 1'b1;

	bv6_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
	);

	bv6_back #(.EID_REF_BYTES(EID_REF_BYTES)) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
		.cfg_we(cfg_valid), .cfg_sel(cfg_index[0]), .cfg_wdata(cfg_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

endmodule

// ===== tb/bundle_v6_header_parser_tb.sv =====
module bundle_v6_header_parser_tb;
	import bv6_pkg::*;

	localparam int REF_BYTES = 4;
	localparam int STALL_LIMIT = 20000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	in_item_t    in_data;
	logic        out_valid;
	logic        out_ready;
	out_item_t   out_data;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [0:0]  cfg_index;
	logic [31:0] cfg_data;

	bundle_v6_header_parser #(.EID_REF_BYTES(REF_BYTES)) DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Software copy of the parser state, advanced once per accepted byte.
	class parse_scoreboard;
		logic [31:0] quota;
		logic [31:0] base;
		logic [4:0]  stage;
		logic [63:0] accum;
		logic [15:0] prim_left;
		logic [31:0] run_left;
		logic [15:0] ref_idx;
		logic [15:0] ref_cnt;
		logic [15:0] dict_size;
		logic [15:0] offs[8];
		logic [15:0] scheme_hold;
		logic [32:0] usage;
		bit          is_frag, last_blk, saw_payload, ref_bad;
		logic [1:0]  status;
		logic [2:0]  err;
		logic [7:0]  kind;
		out_item_t   pending[$];
		int          fails;

		function new();
			quota = QUOTA_RESET;
			base = 32'd0;
			fails = 0;
			restart();
		endfunction

		function void restart();
			stage = ST_VERSION;
			accum = 0;
			prim_left = 0;
			run_left = 0;
			ref_idx = 0;
			ref_cnt = 0;
			dict_size = 0;
			foreach (offs[i]) offs[i] = 0;
			scheme_hold = 0;
			usage = {1'b0, base};
			is_frag = 0; last_blk = 0; saw_payload = 0; ref_bad = 0;
			status = STAT_PARSING;
			err = ERR_NONE;
			kind = 0;
		endfunction

		function int sdnv_bits(logic [4:0] s);
			case (s)
				ST_PROC, ST_FRAG, ST_ADU, ST_BFLAGS, ST_DATALEN: return 32;
				ST_TIMESTAMP, ST_LIFETIME: return 64;
				default: return 16;
			endcase
		endfunction

		function bit charge(logic [63:0] amount);
			usage = usage + amount[32:0];
			return usage > {1'b0, quota};
		endfunction

		function bit pair_valid(logic [15:0] a, logic [15:0] b);
			return a != b && a < dict_size && b < dict_size;
		endfunction

		function logic [4:0] after_block();
			return last_blk ? ST_DONE : ST_TYPE;
		endfunction

		function void note_byte(in_item_t it);
			out_item_t o;
			logic [7:0] b;
			logic [4:0] s, nxt;
			logic [2:0] e;
			int w;
			b = it.data_byte;
			o = '0;
			e = ERR_NONE;
			if (it.frame_start) restart();
			if (status == STAT_PARSING) begin
				s = stage;
				nxt = s;
				if (s >= ST_DEST_SCH && s < ST_TYPE) begin
					if (prim_left == 0) e = ERR_PRIMARY;
					else prim_left--;
				end
				if (e == ERR_NONE) begin
					o.field_id = s;
					if (s == ST_VERSION) begin
						o.field_value = {56'd0, b}; o.field_done = 1; nxt = ST_PROC;
					end else if (s == ST_DICT || s == ST_DATA) begin
						o.field_value = {56'd0, b};
						run_left--;
						if (run_left == 0) begin
							o.field_done = 1;
							if (s == ST_DICT) nxt = is_frag ? ST_FRAG : ST_TYPE;
							else nxt = after_block();
						end
					end else if (s == ST_TYPE) begin
						o.field_value = {56'd0, b}; o.field_done = 1; kind = b;
						if (b == BLK_TYPE_PAYLOAD) saw_payload = 1;
						nxt = ST_BFLAGS;
					end else begin
						w = sdnv_bits(s);
						if ((accum >> (w - 7)) != 0) begin
							e = ERR_SDNV;
						end else begin
							accum = (accum << 7) | {57'd0, b[6:0]};
							o.field_value = accum;
							if (!b[7]) begin
								o.field_done = 1;
								case (s)
									ST_PROC: begin
										if ((accum & PROC_IS_FRAGMENT) != 0) is_frag = 1;
										nxt = ST_PLEN;
									end
									ST_PLEN: begin
										prim_left = accum[15:0];
										nxt = ST_DEST_SCH;
									end
									ST_DLEN: begin
										dict_size = accum[15:0];
										if (dict_size == 0) e = ERR_DICT;
										else begin
											run_left = {16'd0, dict_size};
											if (charge({48'd0, dict_size} + 64'd1)) e = ERR_QUOTA;
											else nxt = ST_DICT;
										end
									end
									ST_ADU: nxt = ST_TYPE;
									ST_BFLAGS: begin
										last_blk = (accum & BLK_FLAG_LAST) != 0;
										nxt = ((accum & BLK_FLAG_HAS_EID) != 0) ? ST_RCNT
											: ST_DATALEN;
									end
									ST_RCNT: begin
										ref_cnt = accum[15:0];
										ref_idx = 0;
										if (charge(64'(REF_BYTES) * {48'd0, ref_cnt})) e = ERR_QUOTA;
										else nxt = (ref_cnt == 0) ? ST_DATALEN : ST_RSCH;
									end
									ST_RSCH: begin
										scheme_hold = accum[15:0];
										nxt = ST_RSSP;
									end
									ST_RSSP: begin
										if (!pair_valid(scheme_hold, accum[15:0])) ref_bad = 1;
										ref_idx++;
										nxt = (ref_idx == ref_cnt) ? ST_DATALEN : ST_RSCH;
									end
									ST_DATALEN: begin
										run_left = accum[31:0];
										if (charge(accum)) e = ERR_QUOTA;
										else nxt = (run_left == 0) ? after_block() : ST_DATA;
									end
									default: begin
										if (s >= ST_DEST_SCH && s < ST_TIMESTAMP)
											offs[s - ST_DEST_SCH] = accum[15:0];
										nxt = s + 5'd1;
									end
								endcase
							end
						end
						if (e == ERR_SDNV) o.field_value = 0;
					end
				end
				if (e != ERR_NONE) begin
					status = STAT_ERROR;
					err = e;
					if (e == ERR_PRIMARY) o.field_id = ST_NONE;
				end else if (nxt != s) begin
					accum = 0;
					stage = nxt;
					if (nxt == ST_DONE) begin
						status = STAT_DONE;
						o.last = 1;
						o.bundle_accepted = saw_payload && !ref_bad;
						for (int k = 0; k < 8; k += 2)
							if (!pair_valid(offs[k], offs[k + 1])) o.bundle_accepted = 0;
					end
				end
			end
			o.block_kind = kind;
			o.parse_status = status;
			o.error_code = err;
			pending.push_back(o);
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %p", $time, got);
				fails++;
				return;
			end
			want = pending.pop_front();
			if (got.field_id !== want.field_id)
				report("field_id", want.field_id, got.field_id);
			if (got.field_value !== want.field_value)
				report("field_value", want.field_value, got.field_value);
			if (got.field_done !== want.field_done)
				report("field_done", want.field_done, got.field_done);
			if (got.block_kind !== want.block_kind)
				report("block_kind", want.block_kind, got.block_kind);
			if (got.parse_status !== want.parse_status)
				report("parse_status", want.parse_status, got.parse_status);
			if (got.error_code !== want.error_code)
				report("error_code", want.error_code, got.error_code);
			if (got.bundle_accepted !== want.bundle_accepted)
				report("bundle_accepted", want.bundle_accepted, got.bundle_accepted);
			if (got.last !== want.last)
				report("last", want.last, got.last);
		endfunction

		function void report(string name, logic [63:0] want, logic [63:0] got);
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
			fails++;
		endfunction
	endclass

	parse_scoreboard sb;
	byte unsigned    bytes_q[$];
	bit              starts_q[$];
	bit              calm;
	bit              hold_off;
	int              idle_cycles;

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// Scoreboard updates on accepted transfers at each rising edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) sb.note_byte(in_data);
			if (out_valid && out_ready) sb.check_result(out_data);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// Receiver side: random stalls, plus one long hold-off when requested.
	initial begin
		out_ready = 0;
		forever begin
			@(negedge clk);
			if (hold_off) begin
				out_ready <= 0;
				repeat (60) @(negedge clk);
				hold_off = 0;
			end
			out_ready <= calm || ($urandom_range(99) >= 10);
		end
	end

	task automatic send_byte(byte unsigned b, bit fs);
		in_data <= '{data_byte: b, frame_start: fs};
		in_valid <= 1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
		if (!calm && $urandom_range(99) < 10) begin
			in_valid <= 0;
			repeat ($urandom_range(4, 1)) @(negedge clk);
		end
	endtask

	task automatic flush_queue();
		while (bytes_q.size() > 0) send_byte(bytes_q.pop_front(), starts_q.pop_front());
	endtask

	task automatic push_byte(byte unsigned b, bit fs = 0);
		bytes_q.push_back(b);
		starts_q.push_back(fs);
	endtask

	task automatic push_sdnv(logic [63:0] v);
		byte unsigned grp[$];
		grp.push_front({1'b0, v[6:0]});
		v = v >> 7;
		while (v != 0) begin
			grp.push_front({1'b1, v[6:0]});
			v = v >> 7;
		end
		foreach (grp[i]) push_byte(grp[i]);
	endtask

	task automatic write_reg(logic [0:0] idx, logic [31:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == CFG_QUOTA) sb.quota = val;
		else sb.base = val;
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	task automatic drain();
		in_valid <= 0;
		while (sb.pending.size() > 0) @(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	// Queues one well-formed bundle; corrupt picks a random spot to break it.
	task automatic push_bundle(int dict_n, int nblocks, bit frag, bit corrupt);
		int bad_at, start_len;
		logic [15:0] o;
		int plen;
		start_len = bytes_q.size();
		bad_at = corrupt ? $urandom_range(60) : -1;
		push_byte(8'h06, 1);
		push_sdnv(frag ? 64'h1 : {55'd0, 8'($urandom_range(255)), 1'b0});
		// primary length covers 8 offsets, ts, seq, lifetime, dlen, dict, frag fields
		plen = 8 * 3 + 10 + 3 + 5 + 3 + dict_n + (frag ? 10 : 0);
		push_sdnv(64'(plen));
		for (int i = 0; i < 8; i++) begin
			o = 16'($urandom_range(dict_n + 1));
			push_sdnv({48'd0, o});
		end
		push_sdnv({$urandom, $urandom} >> $urandom_range(63));
		push_sdnv(64'($urandom_range(65535)));
		push_sdnv({$urandom, $urandom} >> $urandom_range(63));
		push_sdnv(64'(dict_n));
		for (int i = 0; i < dict_n; i++) push_byte(8'($urandom));
		if (frag) begin
			push_sdnv(64'($urandom));
			push_sdnv(64'($urandom));
		end
		for (int blk = 0; blk < nblocks; blk++) begin
			int nref, dlen;
			logic [63:0] fl;
			push_byte((blk == nblocks - 1 || $urandom_range(1)) ? 8'd1 : 8'($urandom));
			nref = ($urandom_range(2) == 0) ? $urandom_range(2) : -1;
			dlen = $urandom_range(3) == 0 ? 0 : $urandom_range(6);
			fl = 64'($urandom_range(63)) & ~64'h48;
			if (blk == nblocks - 1) fl |= BLK_FLAG_LAST;
			if (nref >= 0) fl |= BLK_FLAG_HAS_EID;
			push_sdnv(fl);
			if (nref >= 0) begin
				push_sdnv(64'(nref));
				for (int r = 0; r < nref; r++) begin
					push_sdnv(64'($urandom_range(dict_n + 1)));
					push_sdnv(64'($urandom_range(dict_n + 1)));
				end
			end
			push_sdnv(64'(dlen));
			for (int i = 0; i < dlen; i++) push_byte(8'($urandom));
		end
		if (bad_at >= 0 && start_len + bad_at < bytes_q.size() && bad_at > 0)
			bytes_q[start_len + bad_at] = 8'($urandom);
	endtask

	initial begin
		int sent, phase;
		arst_n = 0;
		in_valid = 0;
		in_data = '0;
		cfg_valid = 0;
		cfg_index = CFG_QUOTA;
		cfg_data = '0;
		calm = 0;
		hold_off = 0;
		idle_cycles = 0;
		sb = new();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Directed: smallest valid bundle, then the error cases.
		push_bundle(1, 1, 0, 0);
		push_byte(8'hFF, 1);              // version byte extremes
		push_byte(8'h00);                 // processing flags 0
		push_byte(8'h00);                 // primary length zero: next byte errors
		push_byte(8'h7F);
		push_byte(8'h80);                 // ignored after error
		push_byte(8'h06, 1);
		for (int i = 0; i < 6; i++) push_byte(8'hFF);  // SDNV overflow on flags
		push_byte(8'h06, 1);
		push_sdnv(0);
		push_sdnv(40);
		for (int i = 0; i < 11; i++) push_sdnv(0);
		push_sdnv(0);                     // empty dictionary
		flush_queue();
		drain();

		// Quota: tiny limit, then extremes of the registers.
		write_reg(CFG_QUOTA, 32'd0);
		write_reg(CFG_BASE, 32'd0);
		push_bundle(2, 1, 1, 0);
		flush_queue();
		drain();
		write_reg(CFG_QUOTA, 32'hFFFF_FFFF);
		write_reg(CFG_BASE, 32'hFFFF_FFF0);
		push_bundle(3, 2, 0, 0);
		push_bundle(3, 1, 1, 0);
		flush_queue();
		drain();
		write_reg(CFG_QUOTA, 32'd40);
		write_reg(CFG_BASE, 32'd10);

		// Random bundles; a middle stretch runs without idling and carries the hold-off.
		sent = 0;
		phase = 0;
		while (sent < 300) begin
			int before_n, nbytes;
			if (phase == 0 && sent >= 60) begin
				calm = 1;
				hold_off = 1;
				phase = 1;
			end
			if (phase == 1 && sent >= 160) begin
				calm = 0;
				phase = 2;
			end
			if (phase == 2 && sent >= 220) begin
				flush_queue();
				drain();
				write_reg(CFG_QUOTA, QUOTA_RESET);
				write_reg(CFG_BASE, $urandom_range(200));
				phase = 3;
			end
			before_n = bytes_q.size();
			if ($urandom_range(9) == 0) begin
				nbytes = $urandom_range(8, 1);
				for (int i = 0; i < nbytes; i++)
					push_byte(8'($urandom), 1'($urandom_range(1)));
			end else begin
				push_bundle($urandom_range(8, 1), $urandom_range(3, 1), $urandom_range(3) == 0,
					$urandom_range(4) == 0);
			end
			sent += bytes_q.size() - before_n;
			flush_queue();
		end
		drain();

		if (sb.fails == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
